FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; empty bodies under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside of reset.
`define DRLE_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true outside of reset.
`define DRLE_NEVER(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define DRLE_ASSERT(name, clk, rst_n, prop, msg)
`define DRLE_NEVER(name, clk, rst_n, cond, msg)

`endif

`endif

FILE: rtl/drle_pkg.sv
// ----------------------------------------------------------------------------
// drle_pkg
// Types and constants of the delta run-length encoder.
// ----------------------------------------------------------------------------
package drle_pkg;

    localparam logic [5:0]  RUN_MAX      = 6'd63;
    localparam logic [15:0] NARROW_POS   = 16'd62;     // largest narrow delta
    localparam logic [15:0] NARROW_NEG   = 16'hFFC2;   // -62, smallest narrow delta
    localparam logic        MARK_BIT     = 1'b1;

    localparam logic [1:0]  CNT_NONE     = 2'd0;
    localparam logic [1:0]  CNT_ONE      = 2'd1;
    localparam logic [1:0]  CNT_TWO      = 2'd2;

    // Up to three output words caused by one sample.
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] bytes;
        logic            last;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

FILE: rtl/delta_run_length_encoder_unit.sv
// ----------------------------------------------------------------------------
// delta_run_length_encoder_unit
// Delta run-length encoder: 16-bit signed samples in, encoded bytes out.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready): one sample word per handshake with
// i_first_sample marking a block start (sent raw, two bytes) and
// i_last_sample marking its end (pending run flushed).
// Output channel (o_valid/i_ready): one byte word per handshake;
// o_last_byte flags the final byte caused by a last sample.
// A sample yields zero to three bytes. The front takes one sample per cycle
// while the queue has room; the back drains one byte per cycle while i_ready
// is high, so sustained throughput is one sample per cycle until the byte
// rate, set by the single output register, becomes the limit. A sample's
// first byte passes the group queue, group register and output register.
// Receiver stalls fill the QUEUE_DEPTH-entry group queue, then o_ready drops.
// Reset (synchronous, active low) empties the queue and output register and
// returns the encoder state to: previous sample 0, previous delta 0, wide
// mode, run length 0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module delta_run_length_encoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_sample,
    input  logic               i_first_sample,
    input  logic               i_last_sample,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_out_byte,
    output logic               o_last_byte
);

    logic                accept;
    logic                push;
    logic                pop;
    drle_pkg::t_cmd      cmd;
    drle_pkg::t_cmd      head;
    drle_pkg::t_q_status q_status;

    assign o_ready = !q_status.full;
    assign accept  = i_valid && o_ready;

    drle_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_sample       (i_sample),
        .i_first_sample (i_first_sample),
        .i_last_sample  (i_last_sample),
        .o_push         (push),
        .o_cmd          (cmd)
    );

    drle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (cmd),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    drle_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_status    (q_status),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

    `DRLE_NEVER(a_push_full, i_clk, i_rst_n, push && q_status.full, "push into full queue")
    `DRLE_NEVER(a_pop_empty, i_clk, i_rst_n, pop && q_status.empty, "pop from empty queue")
    `DRLE_ASSERT(a_first_raw, i_clk, i_rst_n, (accept && i_first_sample) |-> (push && (cmd.count == drle_pkg::CNT_TWO)), "block start must push two raw bytes")
    `DRLE_NEVER(a_push_count, i_clk, i_rst_n, push && (cmd.count == drle_pkg::CNT_NONE), "pushed group without bytes")

endmodule

FILE: rtl/drle_front.sv
// ----------------------------------------------------------------------------
// drle_front
// Takes samples, tracks delta/run state and builds the word group per sample.
// ----------------------------------------------------------------------------
module drle_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic signed [15:0] i_sample,
    input  logic               i_first_sample,
    input  logic               i_last_sample,
    output logic               o_push,
    output drle_pkg::t_cmd     o_cmd
);

    logic [15:0] r_prev_sample, n_prev_sample;
    logic [15:0] r_prev_delta,  n_prev_delta;
    logic        r_wide,        n_wide;
    logic [5:0]  r_run,         n_run;

    logic [15:0] delta;
    logic        mode;
    logic [5:0]  run_inc;
    logic        marker;
    logic [7:0]  dbyte0;
    logic [7:0]  dbyte1;

    always_comb begin
        delta   = $unsigned(i_sample) - r_prev_sample;
        mode    = !((delta <= drle_pkg::NARROW_POS) || (delta >= drle_pkg::NARROW_NEG));
        run_inc = r_run + 6'd1;
        marker  = (r_run != 6'd0) || (mode != r_wide);
        if (mode) begin
            dbyte0 = {1'b0, delta[14:8]};
            dbyte1 = delta[7:0];
        end else begin
            dbyte0 = {1'b0, delta[6:0]};
            dbyte1 = 8'h00;
        end

        n_prev_sample = $unsigned(i_sample);
        n_prev_delta  = r_prev_delta;
        n_wide        = r_wide;
        n_run         = r_run;
        o_cmd.count   = drle_pkg::CNT_NONE;
        o_cmd.bytes   = '0;
        o_cmd.last    = i_last_sample;

        if (i_first_sample) begin
            o_cmd.count    = drle_pkg::CNT_TWO;
            o_cmd.bytes[0] = i_sample[15:8];
            o_cmd.bytes[1] = i_sample[7:0];
            n_prev_delta   = '0;
            n_wide         = 1'b1;
            n_run          = '0;
        end else if (delta == r_prev_delta) begin
            if ((run_inc == drle_pkg::RUN_MAX) || i_last_sample) begin
                o_cmd.count    = drle_pkg::CNT_ONE;
                o_cmd.bytes[0] = {drle_pkg::MARK_BIT, mode, run_inc};
                n_wide         = mode;
                n_run          = '0;
            end else begin
                n_run = run_inc;
            end
        end else begin
            if (marker) begin
                o_cmd.bytes[0] = {drle_pkg::MARK_BIT, mode, r_run};
                o_cmd.bytes[1] = dbyte0;
                o_cmd.bytes[2] = dbyte1;
            end else begin
                o_cmd.bytes[0] = dbyte0;
                o_cmd.bytes[1] = dbyte1;
            end
            o_cmd.count  = {1'b0, marker} + (mode ? drle_pkg::CNT_TWO : drle_pkg::CNT_ONE);
            n_prev_delta = delta;
            n_wide       = mode;
            n_run        = '0;
        end

        o_push = i_accept && (o_cmd.count != drle_pkg::CNT_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_sample <= '0;
            r_prev_delta  <= '0;
            r_wide        <= 1'b1;
            r_run         <= '0;
        end else if (i_accept) begin
            r_prev_sample <= n_prev_sample;
            r_prev_delta  <= n_prev_delta;
            r_wide        <= n_wide;
            r_run         <= n_run;
        end
    end

endmodule

FILE: rtl/drle_queue.sv
// ----------------------------------------------------------------------------
// drle_queue
// Small FIFO of word groups between the front and the back.
// ----------------------------------------------------------------------------
module drle_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  drle_pkg::t_cmd        i_cmd,
    input  logic                  i_pop,
    output drle_pkg::t_cmd        o_head,
    output drle_pkg::t_q_status   o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    drle_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;

    function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/drle_back.sv
// ----------------------------------------------------------------------------
// drle_back
// Unpacks word groups from the queue into a registered byte stream.
// ----------------------------------------------------------------------------
module drle_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  drle_pkg::t_cmd       i_head,
    input  drle_pkg::t_q_status  i_status,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_out_byte,
    output logic                 o_last_byte
);

    drle_pkg::t_cmd r_cmd;
    logic           r_busy;
    logic [1:0]     r_idx;

    logic take;
    logic done;
    logic slot_free;

    always_comb begin
        take      = !o_valid || i_ready;
        done      = (r_idx == (r_cmd.count - 2'd1));
        slot_free = !r_busy || (take && done);
        o_pop     = slot_free && !i_status.empty;
    end

    // group being unpacked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (slot_free) begin
            r_busy <= 1'b0;
        end else if (take) begin
            r_idx  <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (take) begin
            o_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && r_busy) begin
            o_out_byte  <= r_cmd.bytes[r_idx];
            o_last_byte <= r_cmd.last && done;
        end
    end

endmodule
